@@ rtl/mbrm_pkg.sv @@
package mbrm_pkg;

  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_BYTE  = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;

  localparam logic [0:0] REG_TIMEOUT = 1'b0;
  localparam logic [0:0] REG_RETRY   = 1'b1;

  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  localparam logic [7:0] FUNC_READ  = 8'h03;
  localparam logic [7:0] BYTE_COUNT = 8'h02;
  localparam logic [7:0] ZERO_BYTE  = 8'h00;
  localparam logic [7:0] QTY_LO     = 8'h01;

  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
  localparam logic [15:0] RETRY_RESET   = 16'd100;
  localparam logic [15:0] TICK_MAX      = 16'hFFFF;

  // request word positions
  localparam logic [2:0] POS_FUNC   = 3'd1;
  localparam logic [2:0] POS_REG_HI = 3'd2;
  localparam logic [2:0] POS_REG_LO = 3'd3;
  localparam logic [2:0] POS_QTY_HI = 3'd4;
  localparam logic [2:0] POS_QTY_LO = 3'd5;
  localparam logic [2:0] POS_CRC_LO = 3'd6;
  localparam logic [2:0] POS_CRC_HI = 3'd7;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] slave_address;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] tx_byte;
    logic       last;
    logic [15:0] wind_tenths;
    logic       status;
  } out_item_t;

  typedef struct packed {
    logic [15:0] timeout_ticks;
    logic [15:0] retry_ticks;
  } cfg_t;

  // work handed from the front to the back
  typedef struct packed {
    logic        is_done;
    logic [7:0]  addr;
    logic [15:0] value;
    logic        status;
  } job_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) c = (c >> 1) ^ CRC_POLY;
      else c = c >> 1;
    end
    return c;
  endfunction

endpackage

@@ rtl/mbrm_queue.sv @@
module mbrm_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  mbrm_pkg::job_t push_job,
  input  logic          pop,
  output mbrm_pkg::job_t head_job,
  output logic          empty,
  output logic          full
);
  import mbrm_pkg::*;

  job_t mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;

  assign empty    = (count == '0);
  assign full     = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign head_job = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) mem[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) wr_ptr <= wr_ptr + 1'b1;
      if (pop && !empty) rd_ptr <= rd_ptr + 1'b1;
      case ({push && !full, pop && !empty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/mbrm_front.sv @@
module mbrm_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  mbrm_pkg::in_item_t in_item,
  input  mbrm_pkg::cfg_t     cfg,
  input  logic               queue_full,
  output logic               push,
  output mbrm_pkg::job_t     job
);
  import mbrm_pkg::*;

  typedef enum logic [2:0] {
    PH_ADDR, PH_FUNC, PH_COUNT, PH_DATA_HI, PH_DATA_LO, PH_CRC_LO, PH_CRC_HI
  } phase_t;

  logic        busy, busy_next;
  logic [7:0]  target_address, target_address_next;
  phase_t      phase, phase_next;
  logic [15:0] value_bytes, value_bytes_next;
  logic [7:0]  crc_low_seen, crc_low_seen_next;
  logic [15:0] rx_crc, rx_crc_next;
  logic [15:0] elapsed_ticks, elapsed_ticks_next;
  logic [15:0] since_send_ticks, since_send_ticks_next;
  logic        accept;
  logic [15:0] crc_step;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;
  assign crc_step = crc16_byte(rx_crc, in_item.rx_byte);

  always_comb begin
    busy_next             = busy;
    target_address_next   = target_address;
    phase_next            = phase;
    value_bytes_next      = value_bytes;
    crc_low_seen_next     = crc_low_seen;
    rx_crc_next           = rx_crc;
    elapsed_ticks_next    = elapsed_ticks;
    since_send_ticks_next = since_send_ticks;
    push                  = 1'b0;
    job                   = '{is_done: 1'b0, addr: target_address, value: 16'h0000,
                              status: 1'b0};
    if (accept) begin
      if (in_item.action == ACT_START) begin
        busy_next             = 1'b1;
        target_address_next   = in_item.slave_address;
        phase_next            = PH_ADDR;
        value_bytes_next      = '0;
        crc_low_seen_next     = '0;
        rx_crc_next           = CRC_INIT;
        elapsed_ticks_next    = '0;
        since_send_ticks_next = '0;
        push                  = 1'b1;
        job.addr              = in_item.slave_address;
      end else if (busy && in_item.action == ACT_BYTE) begin
        case (phase)
          PH_ADDR: begin
            if (in_item.rx_byte == target_address) begin
              rx_crc_next = crc16_byte(CRC_INIT, in_item.rx_byte);
              phase_next  = PH_FUNC;
            end
          end
          PH_FUNC: begin
            if (in_item.rx_byte == FUNC_READ) begin
              rx_crc_next = crc_step;
              phase_next  = PH_COUNT;
            end else begin
              phase_next = PH_ADDR;
            end
          end
          PH_COUNT: begin
            if (in_item.rx_byte == BYTE_COUNT) begin
              rx_crc_next = crc_step;
              phase_next  = PH_DATA_HI;
            end else begin
              phase_next = PH_ADDR;
            end
          end
          PH_DATA_HI: begin
            value_bytes_next = {in_item.rx_byte, 8'h00};
            rx_crc_next      = crc_step;
            phase_next       = PH_DATA_LO;
          end
          PH_DATA_LO: begin
            value_bytes_next = {value_bytes[15:8], in_item.rx_byte};
            rx_crc_next      = crc_step;
            phase_next       = PH_CRC_LO;
          end
          PH_CRC_LO: begin
            crc_low_seen_next = in_item.rx_byte;
            phase_next        = PH_CRC_HI;
          end
          PH_CRC_HI: begin
            phase_next = PH_ADDR;
            if (crc_low_seen == rx_crc[7:0] && in_item.rx_byte == rx_crc[15:8]) begin
              busy_next = 1'b0;
              push      = 1'b1;
              job       = '{is_done: 1'b1, addr: target_address, value: value_bytes,
                            status: 1'b0};
            end
          end
          default: phase_next = PH_ADDR;
        endcase
      end else if (busy && in_item.action == ACT_TICK) begin
        if (elapsed_ticks >= cfg.timeout_ticks) begin
          busy_next  = 1'b0;
          phase_next = PH_ADDR;
          push       = 1'b1;
          job        = '{is_done: 1'b1, addr: target_address, value: 16'h0000,
                         status: 1'b1};
        end else begin
          elapsed_ticks_next = elapsed_ticks + 1'b1;
          if (since_send_ticks >= cfg.retry_ticks) begin
            since_send_ticks_next = '0;
            push                  = 1'b1;
          end else if (since_send_ticks != TICK_MAX) begin
            since_send_ticks_next = since_send_ticks + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy             <= 1'b0;
      target_address   <= '0;
      phase            <= PH_ADDR;
      value_bytes      <= '0;
      crc_low_seen     <= '0;
      rx_crc           <= CRC_INIT;
      elapsed_ticks    <= '0;
      since_send_ticks <= '0;
    end else begin
      busy             <= busy_next;
      target_address   <= target_address_next;
      phase            <= phase_next;
      value_bytes      <= value_bytes_next;
      crc_low_seen     <= crc_low_seen_next;
      rx_crc           <= rx_crc_next;
      elapsed_ticks    <= elapsed_ticks_next;
      since_send_ticks <= since_send_ticks_next;
    end
  end

endmodule

@@ rtl/mbrm_back.sv @@
module mbrm_back (
  input  logic                clk,
  input  logic                rst,
  input  mbrm_pkg::job_t      head_job,
  input  logic                empty,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output mbrm_pkg::out_item_t out_item
);
  import mbrm_pkg::*;

  logic        active;
  logic [2:0]  pos;
  logic [7:0]  addr;
  logic [15:0] crc;
  logic        load;
  logic [7:0]  tx;

  assign load = !out_valid || out_ready;
  assign pop  = load && !active && !empty;

  always_comb begin
    case (pos)
      POS_FUNC:   tx = FUNC_READ;
      POS_REG_HI: tx = ZERO_BYTE;
      POS_REG_LO: tx = ZERO_BYTE;
      POS_QTY_HI: tx = ZERO_BYTE;
      POS_QTY_LO: tx = QTY_LO;
      POS_CRC_LO: tx = crc[7:0];
      POS_CRC_HI: tx = crc[15:8];
      default:    tx = addr;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
      pos       <= '0;
    end else if (load) begin
      if (active) begin
        out_valid <= 1'b1;
        out_item  <= '{kind: 1'b0, tx_byte: tx, last: (pos == POS_CRC_HI),
                       wind_tenths: 16'h0000, status: 1'b0};
        // crc runs over the six header words as they go out
        if (pos < POS_CRC_LO) crc <= crc16_byte(crc, tx);
        pos <= pos + 1'b1;
        if (pos == POS_CRC_HI) active <= 1'b0;
      end else if (!empty) begin
        out_valid <= 1'b1;
        if (head_job.is_done) begin
          out_item <= '{kind: 1'b1, tx_byte: 8'h00, last: 1'b1,
                        wind_tenths: head_job.value, status: head_job.status};
        end else begin
          out_item <= '{kind: 1'b0, tx_byte: head_job.addr, last: 1'b0,
                        wind_tenths: 16'h0000, status: 1'b0};
          addr   <= head_job.addr;
          crc    <= crc16_byte(CRC_INIT, head_job.addr);
          pos    <= POS_FUNC;
          active <= 1'b1;
        end
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/modbus_rtu_register_read_master.sv @@
// modbus rtu master that reads one holding register
// input channel (in_valid/in_ready/in_item): action 0 starts a read of the
// given slave address, action 1 carries a received serial byte, action 2 is a
// one millisecond tick. output channel (out_valid/out_ready/out_item): each
// word is either a request byte to transmit (kind 0) or the end of a read
// (kind 1) with the register value or a timeout status; last marks the final
// word caused by one input word.
// apb port: timeout_ticks at 0x0, retry_ticks at 0x4, low 16 bits used.
// throughput: one input word per cycle while the four-entry job queue has room.
// a start or a retry produces eight request words, one per cycle while the
// receiver is ready; the sequencer sends all eight before the next job, and a
// finished read gives one word. jobs reach the output register via the queue.
// when the receiver stalls, the output register holds and the queue fills;
// in_ready drops once it is full. synchronous reset clears the parser,
// counters and queue and loads the register defaults 1000 and 100.
module modbus_rtu_register_read_master (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  mbrm_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output mbrm_pkg::out_item_t out_item,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import mbrm_pkg::*;

  cfg_t cfg;
  job_t push_job;
  job_t head_job;
  logic push;
  logic pop;
  logic empty;
  logic full;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout_ticks <= TIMEOUT_RESET;
      cfg.retry_ticks   <= RETRY_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_TIMEOUT) cfg.timeout_ticks <= pwdata[15:0];
      else cfg.retry_ticks <= pwdata[15:0];
    end
  end

  assign prdata = (paddr[2] == REG_RETRY) ? {16'h0000, cfg.retry_ticks}
                                          : {16'h0000, cfg.timeout_ticks};

  mbrm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .cfg       (cfg),
    .queue_full(full),
    .push      (push),
    .job       (push_job)
  );

  mbrm_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_job(push_job),
    .pop     (pop),
    .head_job(head_job),
    .empty   (empty),
    .full    (full)
  );

  mbrm_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head_job (head_job),
    .empty    (empty),
    .pop      (pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

endmodule

@@ rtl/mbrm_checker.sv @@
module mbrm_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input mbrm_pkg::out_item_t out_item
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("output word changed while stalled");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.kind |-> out_item.last && out_item.tx_byte == 8'h00)
    else $error("finished read word must be last with zero byte");

  a_tx_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.kind |-> !out_item.status && out_item.wind_tenths == 16'h0000)
    else $error("transmit word carries read fields");

  a_timeout_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.kind && out_item.status |-> out_item.wind_tenths == 16'h0000)
    else $error("timeout word carries a value");

  a_ready_after_reset: assert property (@(posedge clk)
    rst |=> in_ready && !out_valid)
    else $error("block not empty after reset");

endmodule

bind modbus_rtu_register_read_master mbrm_checker u_mbrm_checker (.*);
